// ----- rtl/srrq_pkg.sv -----
`default_nettype none

package srrq_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned OCC_W  = 4;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

  // status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // what one cell loads this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic             fetch_ok;
    logic [OCC_W-1:0] occupancy;
  } srrq_res_t;

endpackage

`default_nettype wire

// ----- rtl/shift_register_request_queue.sv -----
// results are registered: a result appears in the cycle after its command transfer
// throughput: one command per cycle while the output register is empty or taken; the cells update in parallel
// the output register frees up in the same cycle it is taken, so no bubbles while m_axis_tready holds
// reset: clears every entry to zero, the occupancy count and the output valid
`default_nettype none

module shift_register_request_queue
  import srrq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [2:0] cmd, [10:3] request, [13:11] position, [15:14] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [1:0] status, [9:2] head_data, [13:10] occupancy, [15:14] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] request;
  logic [POS_W-1:0]  position;
  logic              accept;
  cell_op_e          cell_op [DEPTH];
  logic [DATA_W-1:0] ent [DEPTH];
  srrq_res_t         res;

  logic              out_valid_q;
  logic [STS_W-1:0]  status_q;
  logic [DATA_W-1:0] head_q;
  logic [OCC_W-1:0]  occ_q;

  assign cmd      = s_axis_tdata[CMD_W-1:0];
  assign request  = s_axis_tdata[CMD_W+DATA_W-1:CMD_W];
  assign position = s_axis_tdata[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  srrq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd),
    .position_i (position),
    .cell_op_o  (cell_op),
    .res_o      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_prev
      assign prev = ent[i-1];
    end
    // zero shifts in behind the tail on a fetch
    if (i == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_next
      assign next = ent[i+1];
    end
    srrq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (cell_op[i]),
      .req_i  (request),
      .prev_i (prev),
      .next_i (next),
      .data_o (ent[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= res.status;
      head_q   <= res.fetch_ok ? ent[0] : '0;
      occ_q    <= res.occupancy;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, occ_q, head_q, status_q};

endmodule

`default_nettype wire

// ----- rtl/srrq_cell.sv -----
`default_nettype none

module srrq_cell
  import srrq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_op_e          op_i,
  input  wire logic [DATA_W-1:0] req_i,
  input  wire logic [DATA_W-1:0] prev_i,
  input  wire logic [DATA_W-1:0] next_i,
  output      logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_LOAD:  data_d = req_i;
      CELL_PREV:  data_d = prev_i;
      CELL_NEXT:  data_d = next_i;
      CELL_CLEAR: data_d = '0;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/srrq_ctrl.sv -----
`default_nettype none

module srrq_ctrl
  import srrq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire logic [POS_W-1:0] position_i,
  output      cell_op_e         cell_op_o [DEPTH],
  output      srrq_res_t        res_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] cnt_ext, pos_ext, tgt;
  logic             full, empty, do_ins, do_fetch, do_flush;
  logic [STS_W-1:0] status;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position_i) + CMP_W'(1);

  always_comb begin
    do_ins   = 1'b0;
    do_fetch = 1'b0;
    do_flush = 1'b0;
    status   = ST_OK;
    tgt      = cnt_ext;
    unique case (cmd_i)
      CMD_PUSH, CMD_FRONT, CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          // push appends at count, insert-after saturates to count
          if (cmd_i == CMD_FRONT) begin
            tgt = '0;
          end else if (cmd_i == CMD_INSERT && pos_ext <= cnt_ext) begin
            tgt = pos_ext;
          end
        end
      end
      CMD_FETCH: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_fetch = 1'b1;
        end
      end
      CMD_FLUSH: do_flush = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (do_flush) begin
        count_d = '0;
      end else if (do_ins) begin
        count_d = count_q + CNT_W'(1);
      end else if (do_fetch) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_op
    always_comb begin
      cell_op_o[i] = CELL_HOLD;
      if (accept_i) begin
        if (do_flush) begin
          cell_op_o[i] = CELL_CLEAR;
        end else if (do_fetch) begin
          cell_op_o[i] = CELL_NEXT;
        end else if (do_ins) begin
          if (CMP_W'(i) == tgt) begin
            cell_op_o[i] = CELL_LOAD;
          end else if (CMP_W'(i) > tgt) begin
            cell_op_o[i] = CELL_PREV;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign res_o.status    = status;
  assign res_o.fetch_ok  = do_fetch;
  assign res_o.occupancy = OCC_W'(count_d);

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_flush_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd_i == CMD_FLUSH |=> count_q == '0)
    else $error("flush left entries");

  a_fetch_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd_i == CMD_FETCH && !empty |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("fetch did not drop count");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && full && (cmd_i == CMD_PUSH || cmd_i == CMD_FRONT || cmd_i == CMD_INSERT)
    |=> count_q == CNT_W'(DEPTH))
    else $error("refused push changed count");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import srrq_pkg::*;

  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // commands the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0]        pad;
    logic [OCC_W-1:0]  occupancy;
    logic [DATA_W-1:0] head_data;
    logic [STS_W-1:0]  status;
  } queue_response_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow copy of the queue
  logic [DATA_W-1:0] shadow_bytes [QDEPTH];
  int unsigned       shadow_count;

  queue_response_t pending_responses [$];

  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned refused_count;
  int unsigned empty_fetch_count;
  int unsigned fetched_count;
  int unsigned flush_count;

  shift_register_request_queue #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // updates the shadow queue and returns the response the block must give
  function automatic queue_response_t predict_queue_response(
    input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] req, input logic [POS_W-1:0] pos);
    queue_response_t rsp;
    int              slot;
    int              i;
    rsp = '0;
    rsp.status = ST_OK;
    case (cmd)
      CMD_PUSH, CMD_FRONT, CMD_INSERT: begin
        if (shadow_count >= QDEPTH) begin
          rsp.status = ST_FULL;
          refused_count++;
        end else begin
          if (cmd == CMD_PUSH) slot = shadow_count;
          else if (cmd == CMD_FRONT) slot = 0;
          else begin
            // insert past the tail turns into an append
            slot = int'(pos) + 1;
            if (slot > int'(shadow_count)) slot = shadow_count;
          end
          for (i = QDEPTH - 1; i > slot; i--) shadow_bytes[i] = shadow_bytes[i-1];
          shadow_bytes[slot] = req;
          shadow_count++;
        end
      end
      CMD_FETCH: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
          empty_fetch_count++;
        end else begin
          rsp.head_data = shadow_bytes[0];
          for (i = 0; i < QDEPTH - 1; i++) shadow_bytes[i] = shadow_bytes[i+1];
          shadow_bytes[QDEPTH-1] = '0;
          shadow_count--;
          fetched_count++;
        end
      end
      CMD_FLUSH: begin
        for (i = 0; i < QDEPTH; i++) shadow_bytes[i] = '0;
        shadow_count = 0;
        flush_count++;
      end
      default: ;
    endcase
    rsp.occupancy = shadow_count[OCC_W-1:0];
    return rsp;
  endfunction

  task automatic issue_command(
    input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] req, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pos, req, cmd};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_responses.push_back(predict_queue_response(cmd, req, pos));
    sent_count++;
  endtask

  // sender goes quiet until every response is back
  task automatic wait_responses_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request(input logic [CMD_W-1:0] cmd);
    issue_command(cmd, DATA_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 7)));
  endtask

  task automatic test_empty_queue();
    tx_gap_max = 0;
    rx_gap_max = 0;
    issue_command(CMD_FETCH, 8'h00, 3'd0);
    issue_command(CMD_SPARE_FIRST, 8'hFF, 3'd7);
    issue_command(CMD_SPARE_FIRST + 3'd1, 8'h81, 3'd3);
    issue_command(CMD_SPARE_LAST, 8'h7E, 3'd4);
  endtask

  task automatic test_fill_to_full();
    tx_gap_max = 2;
    rx_gap_max = 2;
    issue_command(CMD_PUSH, 8'h00, 3'd7);
    issue_command(CMD_PUSH, 8'hFF, 3'd0);
    issue_command(CMD_FRONT, 8'hA5, 3'd0);
    issue_command(CMD_INSERT, 8'h5A, 3'd0);
    // position well past the tail
    issue_command(CMD_INSERT, 8'h3C, 3'd7);
    issue_command(CMD_INSERT, 8'hC3, 3'd2);
    issue_command(CMD_PUSH, 8'h11, 3'd0);
    issue_command(CMD_FRONT, 8'h22, 3'd0);
    // queue is full now, all three pushes are refused
    issue_command(CMD_PUSH, 8'h33, 3'd0);
    issue_command(CMD_FRONT, 8'h44, 3'd0);
    issue_command(CMD_INSERT, 8'h55, 3'd1);
  endtask

  task automatic test_fetch_and_flush();
    tx_gap_max = 5;
    rx_gap_max = 5;
    issue_command(CMD_FETCH, 8'h00, 3'd0);
    issue_command(CMD_FETCH, 8'hFF, 3'd7);
    issue_command(CMD_SPARE_LAST, 8'h00, 3'd0);
    issue_command(CMD_FLUSH, 8'hFF, 3'd7);
    issue_command(CMD_FETCH, 8'h00, 3'd0);
    issue_command(CMD_FLUSH, 8'h00, 3'd0);
  endtask

  task automatic test_drain_pause();
    int unsigned k;
    tx_gap_max = 0;
    rx_gap_max = 5;
    for (k = 0; k < 6; k++) random_request(CMD_INSERT);
    wait_responses_drained();
    for (k = 0; k < 7; k++) random_request(CMD_FETCH);
  endtask

  task automatic test_random_traffic();
    int unsigned blk;
    int unsigned k;
    int unsigned roll;
    int unsigned push_pct;
    logic [CMD_W-1:0] cmd;
    for (blk = 0; blk < 27; blk++) begin
      case (blk % 3)
        0: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        1: begin
          tx_gap_max = 5;
          rx_gap_max = 5;
        end
        default: begin
          tx_gap_max = $urandom_range(0, 5);
          rx_gap_max = $urandom_range(0, 5);
        end
      endcase
      // fill-heavy, drain-heavy or balanced block
      case ($urandom_range(0, 2))
        0: push_pct = 70;
        1: push_pct = 25;
        default: push_pct = 48;
      endcase
      for (k = 0; k < 50; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_PUSH;
            1: cmd = CMD_FRONT;
            default: cmd = CMD_INSERT;
          endcase
        end else if (roll < 94) cmd = CMD_FETCH;
        else if (roll < 97) cmd = CMD_FLUSH;
        else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        random_request(cmd);
      end
      if (blk % 4 == 3) wait_responses_drained();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : response_check
    queue_response_t want;
    queue_response_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = queue_response_t'(m_axis_tdata);
      if (pending_responses.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: response with nothing pending: tdata=%h", $realtime, m_axis_tdata);
      end else begin
        want = pending_responses.pop_front();
        checked_count++;
        if (got.status != want.status || got.head_data != want.head_data ||
            got.occupancy != want.occupancy || got.pad != want.pad) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: response %0d mismatch: status %0d/%0d data %h/%h occ %0d/%0d pad %b/%b",
                     $realtime, checked_count, want.status, got.status, want.head_data,
                     got.head_data, want.occupancy, got.occupancy, want.pad, got.pad);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
             pending_responses.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_sequence
    int i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_gap_max    = 0;
    rx_gap_max    = 0;
    error_count   = 0;
    for (i = 0; i < QDEPTH; i++) shadow_bytes[i] = '0;
    shadow_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_fetch_and_flush();
    test_drain_pause();
    test_random_traffic();

    wait_responses_drained();
    repeat (4) @(posedge clk_i);
    if (pending_responses.size() != 0) error_count += pending_responses.size();

    $display("%0d commands, %0d responses checked in %0d cycles", sent_count, checked_count,
             cycle_count);
    $display("%0d refused on full, %0d empty fetches, %0d good fetches, %0d flushes",
             refused_count, empty_fetch_count, fetched_count, flush_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
